// ===== design/pmpp_pkg.sv =====
// Shared types, constants and the grey map for the palette match planar packer.
package pmpp_pkg;

  localparam int IDX_W       = 6;
  localparam int RGB_W       = 24;
  localparam int ROW_WIDTH   = 16;
  localparam int COL_W       = 4;
  localparam int PLANES      = 4;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 72;

  localparam logic [IDX_W-1:0] GREY_MAP_LEN     = 6'd17;
  localparam logic [IDX_W-1:0] SWAP_A           = 6'd13;
  localparam logic [IDX_W-1:0] SWAP_B           = 6'd16;
  localparam logic [IDX_W-1:0] PLANE_ZERO_INDEX = 6'd28;
  localparam logic [IDX_W-1:0] PLANE_LIMIT      = 6'd16;
  localparam logic [IDX_W-1:0] PALETTE_COUNT_RST = 6'd16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PALETTE_COUNT = 1'b0,
    REG_STATUE_MODE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
    logic [IDX_W-1:0] entry;
    logic [RGB_W-1:0] rgb;
    logic             found;
    logic [IDX_W-1:0] idx;
  } token_t;

  typedef struct packed {
    logic [IDX_W-1:0]     color_index;
    logic                 not_found;
    logic                 range_warning;
    logic                 row_done;
    logic [ROW_WIDTH-1:0] plane_bit3_row;
    logic [ROW_WIDTH-1:0] plane_bit2_row;
    logic [ROW_WIDTH-1:0] plane_bit1_row;
    logic [ROW_WIDTH-1:0] plane_bit0_row;
  } result_t;

  function automatic logic [IDX_W-1:0] grey_map(input logic [4:0] k);
    logic [IDX_W-1:0] g;
    case (k)
      5'd0:    g = 6'd0;
      5'd1:    g = 6'd1;
      5'd2:    g = 6'd17;
      5'd3:    g = 6'd18;
      5'd4:    g = 6'd19;
      5'd5:    g = 6'd20;
      5'd6:    g = 6'd27;
      5'd7:    g = 6'd22;
      5'd8:    g = 6'd23;
      5'd9:    g = 6'd24;
      5'd10:   g = 6'd25;
      5'd11:   g = 6'd26;
      5'd12:   g = 6'd21;
      5'd13:   g = 6'd15;
      5'd14:   g = 6'd13;
      5'd15:   g = 6'd14;
      5'd16:   g = 6'd14;
      default: g = 6'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/palette_match_planar_packer_unit.sv =====
// A request passes through the cell chain registers and then the output result register.
// Throughput: one request per cycle while not stalled; each request walks the cell chain one cell a cycle.
// The whole chain and the output register advance together; m_tready low while m_tvalid is high stalls all of it.
// Reset clears the pipeline valid bits, the column count, the plane rows and the registers
// (palette_count 16, statue_mode 0); palette entries stay undefined until written.
module palette_match_planar_packer_unit #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pmpp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pmpp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // entry_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30]
  input  logic [pmpp_pkg::IN_DATA_W-1:0]      s_tdata,
  // command[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // color_index[5:0], not_found[6], range_warning[7], plane_bit3_row[23:8],
  // plane_bit2_row[39:24], plane_bit1_row[55:40], plane_bit0_row[71:56]
  output logic [pmpp_pkg::OUT_DATA_W-1:0]     m_tdata,
  // row_done
  output logic                                m_tlast
);

  logic [pmpp_pkg::IDX_W-1:0] palette_count;
  logic                       statue_mode;
  logic                       adv;
  pmpp_pkg::token_t           chain [PALETTE_DEPTH+1];
  pmpp_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= pmpp_pkg::PALETTE_COUNT_RST;
      statue_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pmpp_pkg::REG_PALETTE_COUNT: palette_count <= cfg_wdata;
        pmpp_pkg::REG_STATUE_MODE:   statue_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !rst;

  always_comb begin
    chain[0].valid = s_tvalid;
    chain[0].cmd   = pmpp_pkg::cmd_t'(s_tuser);
    chain[0].entry = s_tdata[5:0];
    chain[0].rgb   = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
    chain[0].found = 1'b0;
    chain[0].idx   = '0;
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pmpp_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .palette_count(palette_count),
      .tok_in       (chain[i]),
      .tok_out      (chain[i+1])
    );
  end

  pmpp_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .palette_count(palette_count),
    .statue_mode  (statue_mode),
    .tok          (chain[PALETTE_DEPTH]),
    .out_valid    (m_tvalid),
    .res          (res)
  );

  assign m_tdata = {res.plane_bit0_row, res.plane_bit1_row, res.plane_bit2_row,
                    res.plane_bit3_row, res.range_warning, res.not_found,
                    res.color_index};
  assign m_tlast = res.row_done;

endmodule

// ===== design/pmpp_cell.sv =====
// One palette cell: holds one entry, matches passing pixels and takes its own writes.
module pmpp_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [pmpp_pkg::IDX_W-1:0]    palette_count,
  input  pmpp_pkg::token_t              tok_in,
  output pmpp_pkg::token_t              tok_out
);

  localparam logic [pmpp_pkg::IDX_W-1:0] MY_IDX = pmpp_pkg::IDX_W'(CELL_INDEX);

  logic [pmpp_pkg::RGB_W-1:0] entry;
  pmpp_pkg::token_t           tok_next;
  logic                       hit;

  assign hit = tok_in.cmd == pmpp_pkg::CMD_PIXEL && !tok_in.found &&
               MY_IDX < palette_count && entry == tok_in.rgb;

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_in.valid && tok_in.cmd == pmpp_pkg::CMD_WRITE && tok_in.entry == MY_IDX) begin
      entry <= tok_in.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/pmpp_packer.sv =====
// Index remap, bitplane row accumulation and the output result register.
module pmpp_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [pmpp_pkg::IDX_W-1:0]    palette_count,
  input  logic                          statue_mode,
  input  pmpp_pkg::token_t              tok,
  output logic                          out_valid,
  output pmpp_pkg::result_t             res
);

  logic [pmpp_pkg::COL_W-1:0]     col;
  logic [pmpp_pkg::ROW_WIDTH-1:0] acc [pmpp_pkg::PLANES];
  logic [pmpp_pkg::ROW_WIDTH-1:0] acc_next [pmpp_pkg::PLANES];
  logic [pmpp_pkg::COL_W-1:0]     col_next;
  pmpp_pkg::result_t              res_next;
  logic [pmpp_pkg::IDX_W-1:0]     k_raw;
  logic [pmpp_pkg::IDX_W-1:0]     k;
  logic [pmpp_pkg::IDX_W-1:0]     pv;
  logic                           warn;
  logic                           last_col;

  always_comb begin
    k_raw = tok.found ? tok.idx : palette_count;
    warn  = 1'b0;
    if (statue_mode) begin
      if (k_raw < pmpp_pkg::GREY_MAP_LEN) begin
        k = pmpp_pkg::grey_map(k_raw[4:0]);
      end else begin
        k    = '0;
        warn = 1'b1;
      end
      pv = k;
    end else begin
      if (k_raw == pmpp_pkg::SWAP_B) begin
        k = pmpp_pkg::SWAP_A;
      end else if (k_raw == pmpp_pkg::SWAP_A) begin
        k = pmpp_pkg::SWAP_B;
      end else begin
        k = k_raw;
      end
      pv = (k == pmpp_pkg::PLANE_ZERO_INDEX) ? '0 : k;
      if (pv >= pmpp_pkg::PLANE_LIMIT) begin
        warn = 1'b1;
      end
    end

    last_col = col == pmpp_pkg::COL_W'(pmpp_pkg::ROW_WIDTH - 1);
    col_next = last_col ? '0 : col + 1'b1;

    for (int p = 0; p < pmpp_pkg::PLANES; p++) begin
      acc_next[p]       = acc[p];
      acc_next[p][~col] = pv[pmpp_pkg::PLANES-1-p];
    end

    res_next = '0;
    if (tok.cmd == pmpp_pkg::CMD_PIXEL) begin
      res_next.color_index   = k;
      res_next.not_found     = !tok.found;
      res_next.range_warning = warn;
      res_next.row_done      = last_col;
      if (last_col) begin
        res_next.plane_bit3_row = acc_next[0];
        res_next.plane_bit2_row = acc_next[1];
        res_next.plane_bit1_row = acc_next[2];
        res_next.plane_bit0_row = acc_next[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok.valid) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col       <= '0;
      for (int p = 0; p < pmpp_pkg::PLANES; p++) begin
        acc[p] <= '0;
      end
    end else if (adv) begin
      out_valid <= tok.valid;
      if (tok.valid && tok.cmd == pmpp_pkg::CMD_PIXEL) begin
        col <= col_next;
        for (int p = 0; p < pmpp_pkg::PLANES; p++) begin
          acc[p] <= last_col ? '0 : acc_next[p];
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the palette match planar packer: palette loads, pixel rows, registers.
module tb;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int IDLE_PCT    = 17;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [pmpp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [pmpp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pmpp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pmpp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;

  palette_match_planar_packer_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // predicted block state
  logic [pmpp_pkg::RGB_W-1:0]     palette_rgb [64];
  logic [pmpp_pkg::ROW_WIDTH-1:0] plane_rows [pmpp_pkg::PLANES];
  logic [pmpp_pkg::COL_W-1:0]     column = '0;
  logic [pmpp_pkg::IDX_W-1:0]     search_count = pmpp_pkg::PALETTE_COUNT_RST;
  logic                           statue_on = 1'b0;
  logic [pmpp_pkg::IDX_W-1:0]     grey_level [pmpp_pkg::GREY_MAP_LEN];

  pmpp_pkg::result_t pending_results [$];

  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;
  logic hold_start = 1'b0;
  int stall_left = 0;

  int error_count = 0;
  int pixel_count = 0;
  int write_count = 0;
  int row_count = 0;
  int miss_count = 0;
  int warn_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic match_and_pack(input pmpp_pkg::cmd_t cmd,
                                input logic [pmpp_pkg::IDX_W-1:0] entry,
                                input logic [pmpp_pkg::RGB_W-1:0] rgb);
    pmpp_pkg::result_t r;
    logic [pmpp_pkg::IDX_W-1:0] k;
    logic [pmpp_pkg::IDX_W-1:0] pv;
    bit miss;
    r = '0;
    if (cmd == pmpp_pkg::CMD_WRITE) begin
      palette_rgb[entry] = rgb;
      pending_results.push_back(r);
      return;
    end
    k = search_count;
    miss = 1'b1;
    for (int i = 0; i < int'(search_count); i++) begin
      if (miss && palette_rgb[i] == rgb) begin
        k = pmpp_pkg::IDX_W'(i);
        miss = 1'b0;
      end
    end
    if (statue_on) begin
      if (k < pmpp_pkg::GREY_MAP_LEN) begin
        k = grey_level[k];
      end else begin
        k = '0;
        r.range_warning = 1'b1;
      end
      pv = k;
    end else begin
      if (k == pmpp_pkg::SWAP_B) k = pmpp_pkg::SWAP_A;
      else if (k == pmpp_pkg::SWAP_A) k = pmpp_pkg::SWAP_B;
      pv = (k == pmpp_pkg::PLANE_ZERO_INDEX) ? '0 : k;
      if (pv >= pmpp_pkg::PLANE_LIMIT) r.range_warning = 1'b1;
    end
    for (int p = 0; p < pmpp_pkg::PLANES; p++)
      plane_rows[p][pmpp_pkg::ROW_WIDTH-1-column] = pv[3-p];
    if (column == pmpp_pkg::COL_W'(pmpp_pkg::ROW_WIDTH-1)) begin
      r.row_done = 1'b1;
      r.plane_bit3_row = plane_rows[0];
      r.plane_bit2_row = plane_rows[1];
      r.plane_bit1_row = plane_rows[2];
      r.plane_bit0_row = plane_rows[3];
      for (int p = 0; p < pmpp_pkg::PLANES; p++) plane_rows[p] = '0;
    end
    column = column + 1'b1;
    r.color_index = k;
    r.not_found = miss;
    pending_results.push_back(r);
  endtask

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    pmpp_pkg::result_t got;
    pmpp_pkg::result_t want;
    if (!rst && s_tvalid && s_tready)
      match_and_pack(pmpp_pkg::cmd_t'(s_tuser), s_tdata[5:0],
                     {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]});
    if (!rst && m_tvalid && m_tready) begin
      got.color_index    = m_tdata[5:0];
      got.not_found      = m_tdata[6];
      got.range_warning  = m_tdata[7];
      got.row_done       = m_tlast;
      got.plane_bit3_row = m_tdata[23:8];
      got.plane_bit2_row = m_tdata[39:24];
      got.plane_bit1_row = m_tdata[55:40];
      got.plane_bit0_row = m_tdata[71:56];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR %0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
      end else begin
        want = pending_results.pop_front();
        row_count  += int'(want.row_done);
        miss_count += int'(want.not_found);
        warn_count += int'(want.range_warning);
        if (got.color_index !== want.color_index || got.not_found !== want.not_found ||
            got.range_warning !== want.range_warning || got.row_done !== want.row_done ||
            got.plane_bit3_row !== want.plane_bit3_row ||
            got.plane_bit2_row !== want.plane_bit2_row ||
            got.plane_bit1_row !== want.plane_bit1_row ||
            got.plane_bit0_row !== want.plane_bit0_row) begin
          error_count++;
          if (error_count <= 10) begin
            $display("ERROR %0t: idx %0d/%0d miss %b/%b warn %b/%b done %b/%b (exp/got)",
                     $time, want.color_index, got.color_index, want.not_found,
                     got.not_found, want.range_warning, got.range_warning,
                     want.row_done, got.row_done);
            $display("  planes exp %h %h %h %h got %h %h %h %h",
                     want.plane_bit3_row, want.plane_bit2_row, want.plane_bit1_row,
                     want.plane_bit0_row, got.plane_bit3_row, got.plane_bit2_row,
                     got.plane_bit1_row, got.plane_bit0_row);
          end
        end
      end
    end
  end

  // receiver: random idling and a counted hold-off
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_start) begin
      m_tready <= 1'b0;
      stall_left <= HOLD_CYCLES;
    end else begin
      m_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_request(input pmpp_pkg::cmd_t cmd,
                              input logic [pmpp_pkg::IDX_W-1:0] entry,
                              input logic [pmpp_pkg::RGB_W-1:0] rgb);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, rgb[7:0], rgb[15:8], rgb[23:16], entry};
    if (cmd == pmpp_pkg::CMD_WRITE) write_count++;
    else pixel_count++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_entry_pixel(input int entry);
    send_request(pmpp_pkg::CMD_PIXEL, pmpp_pkg::IDX_W'($urandom), palette_rgb[entry]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input pmpp_pkg::reg_idx_t idx,
                                input logic [pmpp_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == pmpp_pkg::REG_PALETTE_COUNT) search_count = val;
    else statue_on = val[0];
    @(posedge clk);
  endtask

  task automatic set_registers(input int count, input bit statue);
    wait_idle();
    write_register(pmpp_pkg::REG_PALETTE_COUNT, pmpp_pkg::CFG_DATA_W'(count));
    write_register(pmpp_pkg::REG_STATUE_MODE, pmpp_pkg::CFG_DATA_W'(statue));
    cfg_we <= 1'b0;
  endtask

  task automatic load_palette();
    logic [pmpp_pkg::RGB_W-1:0] colours [64];
    logic [pmpp_pkg::RGB_W-1:0] c;
    bit clash;
    for (int i = 0; i < 64; i++) begin
      do begin
        c = pmpp_pkg::RGB_W'($urandom);
        clash = (c == '0) || (c == '1);
        for (int j = 0; j < i; j++) if (colours[j] == c) clash = 1'b1;
      end while (clash);
      colours[i] = c;
    end
    colours[40] = colours[7];
    colours[63] = '1;
    for (int i = 0; i < 64; i++)
      send_request(pmpp_pkg::CMD_WRITE, pmpp_pkg::IDX_W'(i), colours[i]);
    wait_idle();
  endtask

  task automatic test_directed_row();
    send_entry_pixel(0);
    send_entry_pixel(13);
    send_entry_pixel(15);
    send_request(pmpp_pkg::CMD_WRITE, 6'd63, 24'hFFFFFF);
    send_entry_pixel(16);
    send_request(pmpp_pkg::CMD_PIXEL, 6'd0, 24'h000000);
    send_request(pmpp_pkg::CMD_PIXEL, 6'd63, 24'hFFFFFF);
    for (int i = 1; i <= 12; i++) send_entry_pixel(i);
    send_entry_pixel(14);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    int counts [6];
    bit modes [6];
    counts = '{63, 63, 0, 1, 0, 62};
    modes  = '{1, 0, 0, 1, 1, 0};
    for (int s = 0; s < 6; s++) begin
      set_registers(counts[s], modes[s]);
      send_entry_pixel(40);
      send_entry_pixel(28);
      send_entry_pixel(16);
      send_entry_pixel(13);
      send_entry_pixel(6);
      send_entry_pixel(62);
      send_request(pmpp_pkg::CMD_PIXEL, 6'd21, 24'h000000);
      send_entry_pixel(0);
    end
    wait_idle();
  endtask

  task automatic random_item();
    int roll;
    int lim;
    int pick;
    logic [pmpp_pkg::RGB_W-1:0] c;
    roll = int'($urandom_range(99));
    lim = int'(search_count);
    if (roll < 8) begin
      c = $urandom_range(1) ? pmpp_pkg::RGB_W'($urandom) : palette_rgb[$urandom_range(63)];
      send_request(pmpp_pkg::CMD_WRITE, pmpp_pkg::IDX_W'($urandom_range(63)), c);
    end else if (roll < 70 && lim > 0) begin
      send_entry_pixel(int'($urandom_range(lim - 1)));
    end else if (roll < 80 && lim > 0) begin
      case ($urandom_range(3))
        0: pick = 13;
        1: pick = 16;
        2: pick = 28;
        default: pick = lim - 1;
      endcase
      send_entry_pixel(pick < lim ? pick : lim - 1);
    end else begin
      send_request(pmpp_pkg::CMD_PIXEL, pmpp_pkg::IDX_W'($urandom),
                   pmpp_pkg::RGB_W'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 140; i++) random_item();
    wait_idle();
  endtask

  task automatic test_random_stream();
    int counts [8];
    bit modes [8];
    counts = '{16, 63, 1, 30, 62, 17, 29, 5};
    modes  = '{0, 1, 1, 0, 1, 0, 0, 1};
    for (int s = 0; s < 8; s++) begin
      set_registers(counts[s], modes[s]);
      for (int i = 0; i < 60; i++) random_item();
    end
    wait_idle();
  endtask

  initial begin
    grey_level = '{6'd0, 6'd1, 6'd17, 6'd18, 6'd19, 6'd20, 6'd27, 6'd22, 6'd23,
                   6'd24, 6'd25, 6'd26, 6'd21, 6'd15, 6'd13, 6'd14, 6'd14};
    for (int p = 0; p < pmpp_pkg::PLANES; p++) plane_rows[p] = '0;
    for (int i = 0; i < 64; i++) palette_rgb[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    load_palette();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_directed_row();
    test_register_extremes();
    test_backpressure();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    test_random_stream();
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += pending_results.size();
    $display("Covered %0d pixels and %0d palette writes, %0d finished rows,",
             pixel_count, write_count, row_count);
    $display("%0d color misses and %0d range warnings across both modes.",
             miss_count, warn_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
